// ===== src/ath_pkg.sv =====
// ath_pkg: shared types, widths and register codes for the adaptive
// threshold hysteresis unit. No dependencies.
package ath_pkg;

    localparam int SMP_W   = 10;             // sample width
    localparam int TIME_W  = 32;             // timestamp width
    localparam int SMIN_W  = SMP_W;          // span_minimum width
    localparam int DIV_W   = 6;              // band_divisor width
    localparam int DECAY_W = 16;             // decay_interval width
    localparam int CFG_W   = 16;             // widest register
    localparam int IDX_W   = 2;              // register index width
    localparam int SPAN_W  = SMP_W + 1;      // signed span
    localparam int THR_W   = SMP_W + 2;      // signed threshold
    localparam int CNT_W   = $clog2(SMP_W + 1);

    localparam logic [SMIN_W-1:0]  SMIN_RST  = SMIN_W'(30);
    localparam logic [DIV_W-1:0]   DIV_RST   = DIV_W'(6);
    localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(500);

    localparam logic [IDX_W-1:0] REG_SPAN_MIN    = 2'd0;
    localparam logic [IDX_W-1:0] REG_BAND_DIV    = 2'd1;
    localparam logic [IDX_W-1:0] REG_DECAY_INTVL = 2'd2;
    localparam logic [IDX_W-1:0] REG_BLACK_HIGH  = 2'd3;

    typedef struct packed {
        logic [SMP_W-1:0]  sample;
        logic [TIME_W-1:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic             is_black;
        logic             range_valid;
        logic [SMP_W-1:0] low_seen;
        logic [SMP_W-1:0] high_seen;
        logic [SMP_W-1:0] midpoint;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [SMP_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SMP_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRACK,
        ST_DIVIDE,
        ST_DECIDE
    } state_t;

endpackage

// ===== src/ath_in_if.sv =====
// ath_in_if: sample channel (valid, ready, sample and timestamp)
// depends on ath_pkg
interface ath_in_if;
    logic             valid;
    logic             ready;
    ath_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ath_out_if.sv =====
// ath_out_if: result channel (valid, ready, decision and tracked range)
// depends on ath_pkg
interface ath_out_if;
    logic               valid;
    logic               ready;
    ath_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ath_div.sv =====
// ath_div: serial restoring divider, one quotient bit per cycle
// depends on ath_pkg
module ath_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ath_pkg::div_req_t req,
    output ath_pkg::div_rsp_t rsp
);
    import ath_pkg::*;

    logic [SMP_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SMP_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(SMP_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits DIV_W bits
            rem_next = fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            quo_next = {quo_reg[SMP_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running divide");
    a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !$past(req.start) |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== src/adaptive_threshold_hysteresis_unit.sv =====
// adaptive_threshold_hysteresis_unit: top level, sequencer, tracked range
// and decision; depends on ath_pkg, ath_in_if, ath_out_if, ath_div
//
// Each sample beat widens the tracked min/max, narrows it by one on each
// side once decay_interval ms have passed (wrapping 32-bit time) while the
// span exceeds span_minimum, then, if the span is at least span_minimum,
// decides black or white against the midpoint plus or minus span/band_divisor
// (band_divisor 0 acts as 1); otherwise the last decision holds. A sample
// passes from accept to result beat through a range update, the serial
// divider forming the band and its done flag, and a decide step that loads
// the output register when it is free. The sample channel is ready only
// between items; a result may wait in the output register while the next
// sample is taken. Config writes go to index 0 span_minimum, 1 band_divisor,
// 2 decay_interval, 3 black_is_high; the user must make them only while no
// sample is in flight, as the block itself does not enforce this.
module adaptive_threshold_hysteresis_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    ath_in_if.sink                     samples,
    ath_out_if.source                  results,
    input  logic                       cfg_we,
    input  logic [ath_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ath_pkg::CFG_W-1:0]  cfg_data
);
    import ath_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [SMIN_W-1:0]  smin_reg;
    logic [DIV_W-1:0]   bdiv_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic               bhigh_reg;

    // tracked state
    logic [SMP_W-1:0]  lo_reg, lo_next;
    logic [SMP_W-1:0]  hi_reg, hi_next;
    logic              flag_reg, flag_next;
    logic [TIME_W-1:0] last_reg, last_next;

    // per-item payload
    logic [SMP_W-1:0]         smp_reg, smp_next;
    logic [TIME_W-1:0]        now_reg, now_next;
    logic signed [SPAN_W-1:0] span_reg, span_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [SMP_W-1:0]         lo_w, hi_w;
    logic signed [SPAN_W-1:0] span_w, half;
    logic [TIME_W-1:0]        elapsed;
    logic                     due, shrink;
    logic [SMP_W-1:0]         mid;
    logic                     valid_rng;
    logic signed [THR_W-1:0]  thr_hi, thr_lo, v_s;
    logic                     load;

    ath_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // range update datapath
    always_comb
    begin
        lo_w    = (smp_reg < lo_reg) ? smp_reg : lo_reg;
        hi_w    = (smp_reg > hi_reg) ? smp_reg : hi_reg;
        span_w  = $signed({1'b0, hi_w}) - $signed({1'b0, lo_w});
        elapsed = now_reg - last_reg;
        due     = elapsed >= {{(TIME_W-DECAY_W){1'b0}}, decay_reg};
        shrink  = due && (span_w > $signed({{(SPAN_W-SMIN_W){1'b0}}, smin_reg}));
    end

    // decision datapath; span is never below -1, so half is never negative
    always_comb
    begin
        half      = (span_reg + $signed({{(SPAN_W-1){1'b0}}, span_reg[SPAN_W-1]})) >>> 1;
        mid       = lo_reg + half[SMP_W-1:0];
        valid_rng = span_reg >= $signed({{(SPAN_W-SMIN_W){1'b0}}, smin_reg});
        v_s       = $signed({2'b00, smp_reg});
        thr_hi    = $signed({2'b00, mid}) + $signed({2'b00, div_rsp.quotient});
        thr_lo    = $signed({2'b00, mid}) - $signed({2'b00, div_rsp.quotient});
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        flag_next      = flag_reg;
        last_next      = last_reg;
        smp_next       = smp_reg;
        now_next       = now_reg;
        span_next      = span_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        div_req.start    = 1'b0;
        div_req.dividend = span_w[SMP_W-1:0];
        div_req.divisor  = (bdiv_reg == '0) ? DIV_W'(1) : bdiv_reg;
        load             = 1'b0;

        if (results.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    smp_next   = samples.data.sample;
                    now_next   = samples.data.time_ms;
                    state_next = ST_TRACK;
                end
            end
            ST_TRACK:
            begin
                lo_next   = lo_w + {{(SMP_W-1){1'b0}}, shrink};
                hi_next   = hi_w - {{(SMP_W-1){1'b0}}, shrink};
                span_next = span_w - $signed({{(SPAN_W-2){1'b0}}, shrink, 1'b0});
                if (due)
                    last_next = now_reg;
                div_req.start    = 1'b1;
                div_req.dividend = span_next[SMP_W-1:0];
                state_next       = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load = 1'b1;
                    if (valid_rng)
                    begin
                        if (v_s > thr_hi)
                            flag_next = bhigh_reg;
                        else if (v_s < thr_lo)
                            flag_next = !bhigh_reg;
                    end
                    out_data_next.is_black    = flag_next;
                    out_data_next.range_valid = valid_rng;
                    out_data_next.low_seen    = lo_reg;
                    out_data_next.high_seen   = hi_reg;
                    out_data_next.midpoint    = mid;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lo_reg        <= '1;
            hi_reg        <= '0;
            flag_reg      <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            flag_reg      <= flag_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        now_reg      <= now_next;
        span_reg     <= span_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smin_reg  <= SMIN_RST;
            bdiv_reg  <= DIV_RST;
            decay_reg <= DECAY_RST;
            bhigh_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPAN_MIN:    smin_reg  <= cfg_data[SMIN_W-1:0];
                REG_BAND_DIV:    bdiv_reg  <= cfg_data[DIV_W-1:0];
                REG_DECAY_INTVL: decay_reg <= cfg_data[DECAY_W-1:0];
                REG_BLACK_HIGH:  bhigh_reg <= cfg_data[0];
                default:         bhigh_reg <= bhigh_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_track: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> state_reg == ST_TRACK)
        else $error("sample beat did not start range update");
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside divide state");
    a_span_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE |-> span_reg >= $signed({SPAN_W{1'b1}}))
        else $error("tracked range crossed by more than one");
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        load && valid_rng |=> out_data_reg.low_seen <= out_data_reg.midpoint
            && out_data_reg.midpoint <= out_data_reg.high_seen)
        else $error("midpoint outside tracked range");
`endif

endmodule
